// ===== rtl/core/tgarle_pkg.sv =====
// ----------------------------------------------------------------------------
// TGA RLE decoder package
// Shared constants, phase codes and the result word type.
// ----------------------------------------------------------------------------
package tgarle_pkg;

   // Width of the pixel counters and of the pixel_count register
   localparam int PIXEL_COUNT_BITS_DEFAULT = 24;

   // Configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BYTES_PER_PIXEL = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PIXEL_COUNT     = 1'd1;

   localparam logic [2:0] BYTES_PER_PIXEL_RESET = 3'd3;
   localparam logic [2:0] BYTES_PER_PIXEL_MAX   = 3'd4;

   // Decoder phase codes
   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_RAW    = 2'd1;
   localparam logic [1:0] PH_RUN    = 2'd2;

   // One decoded pixel word
   typedef struct packed {
      logic [31:0] pixel_value;
      logic [7:0]  repeat_count;
      logic        last_of_image;
      logic        status;
   } rsp_word_type;

endpackage

// ===== rtl/core/tgarle_csr.sv =====
// ----------------------------------------------------------------------------
// TGA RLE decoder configuration registers
// Holds bytes_per_pixel and pixel_count, written through the csr port.
// ----------------------------------------------------------------------------
module tgarle_csr #(
   parameter int PIXEL_COUNT_BITS = tgarle_pkg::PIXEL_COUNT_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [tgarle_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [PIXEL_COUNT_BITS-1:0]           csr_wr_data,
   output logic [2:0]                            bytes_per_pixel,
   output logic [PIXEL_COUNT_BITS-1:0]           pixel_count
);

   logic [2:0]                  bpp_ff;
   logic [2:0]                  bpp_in;
   logic [PIXEL_COUNT_BITS-1:0] count_ff;
   logic [PIXEL_COUNT_BITS-1:0] count_in;

   always_comb begin
      bpp_in   = bpp_ff;
      count_in = count_ff;
      if (csr_wr_en) begin
         if (csr_index == tgarle_pkg::CSR_BYTES_PER_PIXEL) begin
            bpp_in = csr_wr_data[2:0];
         end
         if (csr_index == tgarle_pkg::CSR_PIXEL_COUNT) begin
            count_in = csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff   <= tgarle_pkg::BYTES_PER_PIXEL_RESET;
         count_ff <= PIXEL_COUNT_BITS'(1);
      end else begin
         bpp_ff   <= bpp_in;
         count_ff <= count_in;
      end
   end

   assign bytes_per_pixel = bpp_ff;
   assign pixel_count     = count_ff;

endmodule

// ===== rtl/core/tgarle_decode.sv =====
// ----------------------------------------------------------------------------
// TGA RLE decoder step logic
// Packet state, pixel gathering and pixel counting for one stream byte.
// ----------------------------------------------------------------------------
module tgarle_decode #(
   parameter int PIXEL_COUNT_BITS = tgarle_pkg::PIXEL_COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [7:0]                    data_byte,
   input  logic [2:0]                    bytes_per_pixel,
   input  logic [PIXEL_COUNT_BITS-1:0]   pixel_count,
   output logic                          emit,
   output tgarle_pkg::rsp_word_type      result
);

   logic [1:0]                  phase_ff;
   logic [1:0]                  phase_in;
   logic [7:0]                  remaining_ff;
   logic [7:0]                  remaining_in;
   logic [1:0]                  byte_index_ff;
   logic [1:0]                  byte_index_in;
   logic [23:0]                 gather_ff;
   logic [23:0]                 gather_in;
   logic [PIXEL_COUNT_BITS-1:0] done_ff;
   logic [PIXEL_COUNT_BITS-1:0] done_in;

   logic                        in_pixel;
   logic                        is_run;
   logic [2:0]                  byte_cnt;
   logic [2:0]                  eff_bpp;
   logic                        complete;
   logic [7:0]                  run_len;
   logic [7:0]                  rem_dec;
   logic [PIXEL_COUNT_BITS:0]   sum;
   logic                        over;
   logic                        last;
   logic                        packet_end;
   logic [31:0]                 pixel;

   always_comb begin
      in_pixel = (phase_ff == tgarle_pkg::PH_RAW) || (phase_ff == tgarle_pkg::PH_RUN);
      is_run   = (phase_ff == tgarle_pkg::PH_RUN);
      byte_cnt = {1'b0, byte_index_ff} + 3'd1;
      if (bytes_per_pixel == 3'd0) begin
         eff_bpp = 3'd1;
      end else if (bytes_per_pixel > tgarle_pkg::BYTES_PER_PIXEL_MAX) begin
         eff_bpp = tgarle_pkg::BYTES_PER_PIXEL_MAX;
      end else begin
         eff_bpp = bytes_per_pixel;
      end
      complete   = in_pixel && (byte_cnt >= eff_bpp);
      run_len    = is_run ? remaining_ff : 8'd1;
      rem_dec    = remaining_ff - 8'd1;
      sum        = {1'b0, done_ff} + (PIXEL_COUNT_BITS+1)'(run_len);
      over       = sum > {1'b0, pixel_count};
      last       = !over && (sum[PIXEL_COUNT_BITS-1:0] == pixel_count);
      packet_end = is_run || (rem_dec == 8'd0);
      pixel      = {8'h00, gather_ff} | ({24'h000000, data_byte} << {byte_index_ff, 3'b000});

      phase_in      = phase_ff;
      remaining_in  = remaining_ff;
      byte_index_in = byte_index_ff;
      gather_in     = gather_ff;
      done_in       = done_ff;

      if (!in_pixel) begin
         // Header: raw holds header+1 pixels, run header-127 copies; both are low7+1
         phase_in      = data_byte[7] ? tgarle_pkg::PH_RUN : tgarle_pkg::PH_RAW;
         remaining_in  = {1'b0, data_byte[6:0]} + 8'd1;
         byte_index_in = 2'd0;
         gather_in     = 24'h000000;
      end else if (!complete) begin
         gather_in     = pixel[23:0];
         byte_index_in = byte_index_ff + 2'd1;
      end else begin
         byte_index_in = 2'd0;
         gather_in     = 24'h000000;
         if (over) begin
            // end the packet and clear the pixel counter, so the next byte starts a new image
            phase_in     = tgarle_pkg::PH_HEADER;
            remaining_in = 8'd0;
            done_in      = '0;
         end else begin
            done_in = sum[PIXEL_COUNT_BITS-1:0];
            if (packet_end) begin
               phase_in     = tgarle_pkg::PH_HEADER;
               remaining_in = 8'd0;
               if (last) begin
                  done_in = '0;
               end
            end else begin
               remaining_in = rem_dec;
            end
         end
      end

      emit                 = complete;
      result.pixel_value   = pixel;
      result.repeat_count  = run_len;
      result.last_of_image = last;
      result.status        = over;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= tgarle_pkg::PH_HEADER;
         remaining_ff  <= 8'd0;
         byte_index_ff <= 2'd0;
         gather_ff     <= 24'h000000;
         done_ff       <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         remaining_ff  <= remaining_in;
         byte_index_ff <= byte_index_in;
         gather_ff     <= gather_in;
         done_ff       <= done_in;
      end
   end

endmodule

// ===== rtl/core/tgarle_out_reg.sv =====
// ----------------------------------------------------------------------------
// TGA RLE decoder result register
// Holds one decoded pixel word until the rsp side takes it.
// ----------------------------------------------------------------------------
module tgarle_out_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  tgarle_pkg::rsp_word_type load_word,
   input  logic                     rsp_stall,
   output logic                     free,
   output logic                     rsp_valid,
   output tgarle_pkg::rsp_word_type rsp_word
);

   logic                     valid_ff;
   logic                     valid_in;
   tgarle_pkg::rsp_word_type word_ff;

   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ===== rtl/core/tga_rle_pixel_decoder_top.sv =====
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder
// Decodes a run-length encoded TGA byte stream into pixel words with repeats.
// ----------------------------------------------------------------------------
// Flow: an accepted byte is registered in the input register and decoded
//   from there; its pixel word, if any, is loaded into the result register.
// Throughput: one byte per cycle, set by the single decode step between the
//   input and result registers; a stalled rsp word holds a pixel's last byte.
// Reset: synchronous; clears both registers' valid bits, the packet state,
//   the pixel counter, and loads bytes_per_pixel 3 and pixel_count 1.
module tga_rle_pixel_decoder_top #(
   parameter int PIXEL_COUNT_BITS = tgarle_pkg::PIXEL_COUNT_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_data_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [31:0]                           rsp_pixel_value,
   output logic [7:0]                            rsp_repeat_count,
   output logic                                  rsp_last_of_image,
   output logic                                  rsp_status,
   input  logic                                  csr_wr_en,
   input  logic [tgarle_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [PIXEL_COUNT_BITS-1:0]           csr_wr_data
);

   logic                        in_valid_ff;
   logic                        in_valid_in;
   logic [7:0]                  in_byte_ff;
   logic                        accept;
   logic                        advance;
   logic                        emit;
   logic                        out_free;
   logic [2:0]                  bytes_per_pixel;
   logic [PIXEL_COUNT_BITS-1:0] pixel_count;
   tgarle_pkg::rsp_word_type    result;
   tgarle_pkg::rsp_word_type    rsp_word;

   tgarle_csr #(
      .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
   ) u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .bytes_per_pixel (bytes_per_pixel),
      .pixel_count     (pixel_count)
   );

   // Header and partial-pixel words produce nothing, so they never wait on rsp
   assign advance   = in_valid_ff && (out_free || !emit);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_data_byte;
      end
   end

   tgarle_decode #(
      .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
   ) u_decode (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .data_byte       (in_byte_ff),
      .bytes_per_pixel (bytes_per_pixel),
      .pixel_count     (pixel_count),
      .emit            (emit),
      .result          (result)
   );

   tgarle_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && emit),
      .load_word (result),
      .rsp_stall (rsp_stall),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   assign rsp_pixel_value   = rsp_word.pixel_value;
   assign rsp_repeat_count  = rsp_word.repeat_count;
   assign rsp_last_of_image = rsp_word.last_of_image;
   assign rsp_status        = rsp_word.status;

endmodule

// ===== rtl/core/tgarle_checker.sv =====
// ----------------------------------------------------------------------------
// TGA RLE decoder port checker
// Watches the top-level ports and flags illegal result words.
// ----------------------------------------------------------------------------
module tgarle_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_pixel_value,
   input logic [7:0]  rsp_repeat_count,
   input logic        rsp_last_of_image,
   input logic        rsp_status
);

   // A stalled word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_value)
         && $stable(rsp_repeat_count) && $stable(rsp_last_of_image)
         && $stable(rsp_status))
      else $error("rsp word changed while stalled");

   a_repeat_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_repeat_count != 8'd0)
      else $error("repeat count of zero");

   // An overrun word never closes the image
   a_last_not_over: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_last_of_image && rsp_status))
      else $error("word marked both last and overrun");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind tga_rle_pixel_decoder_top tgarle_checker u_tgarle_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_pixel_value   (rsp_pixel_value),
   .rsp_repeat_count  (rsp_repeat_count),
   .rsp_last_of_image (rsp_last_of_image),
   .rsp_status        (rsp_status)
);
